FILE: rtl/mpfe_pkg.sv
`timescale 1ns / 1ps

package mpfe_pkg;

	localparam int COLUMNS    = 128;
	localparam int PAGES      = 8;
	localparam int ROWS       = PAGES * 8;
	localparam int STORE_SIZE = COLUMNS * PAGES;
	localparam int HDR_BYTES  = 3;

	localparam int COL_W  = $clog2(COLUMNS);
	localparam int ROW_W  = $clog2(ROWS);
	localparam int PAGE_W = (PAGES > 1) ? $clog2(PAGES) : 1;
	localparam int ADDR_W = $clog2(STORE_SIZE);
	localparam int POS_W  = $clog2(COLUMNS + HDR_BYTES);

	localparam int Q_DEPTH = 4;
	localparam int Q_PTR_W = $clog2(Q_DEPTH);
	localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

	localparam logic [7:0] CMD_PAGE_BASE = 8'hB0;
	localparam logic [7:0] CMD_COL_LOW   = 8'h00;
	localparam logic [7:0] CMD_COL_HIGH  = 8'h10;

	localparam logic [2:0] MODE_POINT   = 3'd0;
	localparam logic [2:0] MODE_FILL    = 3'd1;
	localparam logic [2:0] MODE_CLEAR   = 3'd2;
	localparam logic [2:0] MODE_REFRESH = 3'd3;
	localparam logic [2:0] MODE_TICK    = 3'd4;

	typedef enum logic [2:0] {
		K_POINT   = 3'd0,
		K_FILL    = 3'd1,
		K_CLEAR   = 3'd2,
		K_REFRESH = 3'd3,
		K_TICK    = 3'd4
	} kind_t;

	typedef struct packed {
		kind_t             kind;
		logic              on;
		logic [COL_W-1:0]  c0;
		logic [COL_W-1:0]  c1;
		logic [ROW_W-1:0]  r0;
		logic [ROW_W-1:0]  r1;
	} cmd_t;

	typedef struct packed {
		logic init_busy;
	} back_status_t;

	function automatic logic [PAGE_W-1:0] page_of(input logic [ROW_W-1:0] row);
		return PAGE_W'(row >> 3);
	endfunction

	function automatic logic [ADDR_W-1:0] store_addr(input logic [PAGE_W-1:0] page,
			input logic [COL_W-1:0] col);
		return ADDR_W'(ADDR_W'(page) * ADDR_W'(COLUMNS)) + ADDR_W'(col);
	endfunction

endpackage

FILE: rtl/mpfe_front.sv
`timescale 1ns / 1ps

module mpfe_front (
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [2:0]            mode,
	input  logic [7:0]            col_a,
	input  logic [7:0]            row_a,
	input  logic [7:0]            col_b,
	input  logic [7:0]            row_b,
	input  logic                  pixel_on,
	input  logic                  q_full,
	input  mpfe_pkg::back_status_t status,
	output logic                  push,
	output mpfe_pkg::cmd_t        push_cmd
);

	logic ca_ok, ra_ok, cb_ok, rb_ok, fill_ok, keep;

	assign ca_ok = {1'b0, col_a} < 9'(mpfe_pkg::COLUMNS);
	assign ra_ok = {1'b0, row_a} < 9'(mpfe_pkg::ROWS);
	assign cb_ok = {1'b0, col_b} < 9'(mpfe_pkg::COLUMNS);
	assign rb_ok = {1'b0, row_b} < 9'(mpfe_pkg::ROWS);
	assign fill_ok = ca_ok && ra_ok && (col_a <= col_b) && (row_a <= row_b);

	assign in_stall = status.init_busy || q_full;

	always_comb begin
		keep = 1'b1;
		push_cmd.on = pixel_on;
		push_cmd.c0 = mpfe_pkg::COL_W'(col_a);
		push_cmd.r0 = mpfe_pkg::ROW_W'(row_a);
		push_cmd.c1 = cb_ok ? mpfe_pkg::COL_W'(col_b) : mpfe_pkg::COL_W'(mpfe_pkg::COLUMNS - 1);
		push_cmd.r1 = rb_ok ? mpfe_pkg::ROW_W'(row_b) : mpfe_pkg::ROW_W'(mpfe_pkg::ROWS - 1);
		push_cmd.kind = mpfe_pkg::K_TICK;
		unique case (mode)
			mpfe_pkg::MODE_POINT: begin
				// a point is a one-byte draw
				push_cmd.kind = mpfe_pkg::K_POINT;
				push_cmd.c1 = mpfe_pkg::COL_W'(col_a);
				push_cmd.r1 = mpfe_pkg::ROW_W'(row_a);
				keep = ca_ok && ra_ok;
			end
			mpfe_pkg::MODE_FILL: begin
				push_cmd.kind = fill_ok ? mpfe_pkg::K_FILL : mpfe_pkg::K_REFRESH;
			end
			mpfe_pkg::MODE_CLEAR:   push_cmd.kind = mpfe_pkg::K_CLEAR;
			mpfe_pkg::MODE_REFRESH: push_cmd.kind = mpfe_pkg::K_REFRESH;
			mpfe_pkg::MODE_TICK:    push_cmd.kind = mpfe_pkg::K_TICK;
			default:                keep = 1'b0;
		endcase
	end

	assign push = in_valid && !in_stall && keep;

endmodule

FILE: rtl/mpfe_queue.sv
`timescale 1ns / 1ps

module mpfe_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  mpfe_pkg::cmd_t push_cmd,
	output logic           full,
	input  logic           pop,
	output logic           valid,
	output mpfe_pkg::cmd_t head
);

	mpfe_pkg::cmd_t                 entry_q [mpfe_pkg::Q_DEPTH];
	logic [mpfe_pkg::Q_PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [mpfe_pkg::Q_CNT_W-1:0]   cnt_q;
	logic                           do_pop;

	assign full   = cnt_q == mpfe_pkg::Q_CNT_W'(mpfe_pkg::Q_DEPTH);
	assign valid  = cnt_q != '0;
	assign head   = entry_q[rd_ptr_q];
	assign do_pop = pop && valid;

	always_ff @(posedge clk) begin
		if (push && !full) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push && !full) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if ((push && !full) && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!(push && !full) && do_pop) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

FILE: rtl/mpfe_back.sv
`timescale 1ns / 1ps

module mpfe_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   q_valid,
	input  mpfe_pkg::cmd_t         q_head,
	output logic                   q_pop,
	output mpfe_pkg::back_status_t status,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [7:0]             out_byte,
	output logic                   is_data,
	output logic                   end_of_frame
);

	typedef enum logic [4:0] {
		S_CLEAR   = 5'b00001,
		S_IDLE    = 5'b00010,
		S_DRAW_RD = 5'b00100,
		S_DRAW_WR = 5'b01000,
		S_TICK_RD = 5'b10000
	} state_t;

	state_t                        state_q;
	logic                          init_q;
	logic [mpfe_pkg::ADDR_W-1:0]   clr_addr_q;
	mpfe_pkg::cmd_t                cur_q;
	logic [mpfe_pkg::COL_W-1:0]    f_col_q;
	logic [mpfe_pkg::PAGE_W-1:0]   f_page_q;
	logic                          act_q;
	logic [mpfe_pkg::PAGE_W-1:0]   page_q;
	logic [mpfe_pkg::POS_W-1:0]    pos_q;
	logic                          tk_last_q;
	logic                          out_valid_q;
	logic [7:0]                    out_byte_q;
	logic                          is_data_q;
	logic                          eof_q;

	logic [7:0]                    mem [mpfe_pkg::STORE_SIZE];
	logic [7:0]                    rdata_q;
	logic                          mem_we, mem_re;
	logic [mpfe_pkg::ADDR_W-1:0]   mem_waddr, mem_raddr;
	logic [7:0]                    mem_wdata;

	logic                          out_free, tick_out, is_hdr, pos_end, page_end, draw_end;
	logic                          out_load;
	logic [7:0]                    mask, hdr_byte;
	logic [mpfe_pkg::COL_W-1:0]    data_col;

	function automatic logic [7:0] page_mask(input logic [mpfe_pkg::PAGE_W-1:0] page,
			input logic [mpfe_pkg::ROW_W-1:0] r0, input logic [mpfe_pkg::ROW_W-1:0] r1);
		logic [2:0] lo, hi;
		lo = (page == mpfe_pkg::page_of(r0)) ? r0[2:0] : 3'd0;
		hi = (page == mpfe_pkg::page_of(r1)) ? r1[2:0] : 3'd7;
		return (8'hFF << lo) & (8'hFF >> (3'd7 - hi));
	endfunction

	assign status.init_busy = init_q;
	assign out_free = !out_valid_q || !out_stall;
	assign tick_out = q_head.kind == mpfe_pkg::K_TICK && act_q;
	assign q_pop    = (state_q == S_IDLE) && q_valid && (!tick_out || out_free);
	assign is_hdr   = pos_q < mpfe_pkg::POS_W'(mpfe_pkg::HDR_BYTES);
	assign pos_end  = pos_q == mpfe_pkg::POS_W'(mpfe_pkg::COLUMNS + mpfe_pkg::HDR_BYTES - 1);
	assign page_end = page_q == mpfe_pkg::PAGE_W'(mpfe_pkg::PAGES - 1);
	assign data_col = mpfe_pkg::COL_W'(pos_q - mpfe_pkg::POS_W'(mpfe_pkg::HDR_BYTES));
	assign mask     = page_mask(f_page_q, cur_q.r0, cur_q.r1);
	assign draw_end = (f_col_q == cur_q.c1) && (f_page_q == mpfe_pkg::page_of(cur_q.r1));
	assign out_load = (state_q == S_TICK_RD) || (q_pop && tick_out && is_hdr);

	always_comb begin
		if (pos_q == '0) begin
			hdr_byte = 8'(mpfe_pkg::CMD_PAGE_BASE + 8'(page_q));
		end else if (pos_q == mpfe_pkg::POS_W'(1)) begin
			hdr_byte = mpfe_pkg::CMD_COL_LOW;
		end else begin
			hdr_byte = mpfe_pkg::CMD_COL_HIGH;
		end
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		mem_waddr = mpfe_pkg::store_addr(f_page_q, f_col_q);
		mem_raddr = mpfe_pkg::store_addr(f_page_q, f_col_q);
		mem_wdata = cur_q.on ? (rdata_q | mask) : (rdata_q & ~mask);
		unique case (state_q)
			S_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_addr_q;
				mem_wdata = 8'h00;
			end
			S_IDLE: begin
				mem_re    = q_pop && tick_out && !is_hdr;
				mem_raddr = mpfe_pkg::store_addr(page_q, data_col);
			end
			S_DRAW_RD: mem_re = 1'b1;
			S_DRAW_WR: mem_we = 1'b1;
			S_TICK_RD: ;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rdata_q <= mem[mem_raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			init_q      <= 1'b1;
			clr_addr_q  <= '0;
			f_col_q     <= '0;
			f_page_q    <= '0;
			act_q       <= 1'b0;
			page_q      <= '0;
			pos_q       <= '0;
			tk_last_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_addr_q <= clr_addr_q + 1'b1;
					if (clr_addr_q == mpfe_pkg::ADDR_W'(mpfe_pkg::STORE_SIZE - 1)) begin
						init_q  <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (q_pop) begin
						cur_q    <= q_head;
						f_col_q  <= q_head.c0;
						f_page_q <= mpfe_pkg::page_of(q_head.r0);
						if (q_head.kind == mpfe_pkg::K_FILL || q_head.kind == mpfe_pkg::K_CLEAR
								|| q_head.kind == mpfe_pkg::K_REFRESH) begin
							act_q  <= 1'b1;
							page_q <= '0;
							pos_q  <= '0;
						end
						unique case (q_head.kind)
							mpfe_pkg::K_POINT, mpfe_pkg::K_FILL: state_q <= S_DRAW_RD;
							mpfe_pkg::K_CLEAR: begin
								clr_addr_q <= '0;
								state_q    <= S_CLEAR;
							end
							mpfe_pkg::K_REFRESH: ;
							mpfe_pkg::K_TICK: begin
								if (act_q) begin
									tk_last_q <= pos_end && page_end;
									if (is_hdr) begin
										out_byte_q  <= hdr_byte;
										is_data_q   <= 1'b0;
										eof_q       <= 1'b0;
									end else begin
										state_q <= S_TICK_RD;
									end
									if (pos_end) begin
										pos_q <= '0;
										if (page_end) begin
											act_q  <= 1'b0;
											page_q <= '0;
										end else begin
											page_q <= page_q + 1'b1;
										end
									end else begin
										pos_q <= pos_q + 1'b1;
									end
								end
							end
							default: ;
						endcase
					end
				end
				S_DRAW_RD: state_q <= S_DRAW_WR;
				S_DRAW_WR: begin
					if (draw_end) begin
						state_q <= S_IDLE;
					end else begin
						state_q <= S_DRAW_RD;
						if (f_col_q == cur_q.c1) begin
							f_col_q  <= cur_q.c0;
							f_page_q <= f_page_q + 1'b1;
						end else begin
							f_col_q <= f_col_q + 1'b1;
						end
					end
				end
				S_TICK_RD: begin
					out_byte_q  <= rdata_q;
					is_data_q   <= 1'b1;
					eof_q       <= tk_last_q;
					state_q     <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign out_byte     = out_byte_q;
	assign is_data      = is_data_q;
	assign end_of_frame = eof_q;

endmodule

FILE: rtl/mono_page_framebuffer_engine.sv
`timescale 1ns / 1ps

// Page-mode monochrome frame store (128 columns by 8 pages of column bytes, bit 0 the top
// row) with a byte-serial refresh engine. Requests go into a four-entry queue, so in_stall
// rises only when that queue is full or during the clearing pass after reset, which writes
// the 1024-byte store one byte a cycle. The back end handles one request at a time against
// a single-port store with registered reads: a point or a fill reads and then writes back
// each covered column byte, a clear zeroes the whole store again, a start refresh only
// restarts the byte sequence, and a tick for a data byte reads the store before loading
// the output. Each tick of a running refresh yields one byte on the output register, which
// holds it while out_stall is high; per page the sequence is 0xB0+page, 0x00, 0x10 and then
// 128 data bytes, and end_of_frame marks the last data byte of page 7.
module mono_page_framebuffer_engine (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [2:0] mode,
	input  logic [7:0] col_a,
	input  logic [7:0] row_a,
	input  logic [7:0] col_b,
	input  logic [7:0] row_b,
	input  logic       pixel_on,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       is_data,
	output logic       end_of_frame
);

	mpfe_pkg::back_status_t status;
	mpfe_pkg::cmd_t         push_cmd, head;
	logic                   push, q_full, q_valid, q_pop;

	mpfe_front u_front (
		.in_valid (in_valid),
		.in_stall (in_stall),
		.mode     (mode),
		.col_a    (col_a),
		.row_a    (row_a),
		.col_b    (col_b),
		.row_b    (row_b),
		.pixel_on (pixel_on),
		.q_full   (q_full),
		.status   (status),
		.push     (push),
		.push_cmd (push_cmd)
	);

	mpfe_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (q_full),
		.pop      (q_pop),
		.valid    (q_valid),
		.head     (head)
	);

	mpfe_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_head       (head),
		.q_pop        (q_pop),
		.status       (status),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_byte     (out_byte),
		.is_data      (is_data),
		.end_of_frame (end_of_frame)
	);

endmodule

FILE: rtl/mpfe_checker.sv
`timescale 1ns / 1ps

module mpfe_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] out_byte,
	input logic       is_data,
	input logic       end_of_frame
);

	// output register holds a stalled byte
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(is_data)
			&& $stable(end_of_frame))
		else $error("stalled output byte changed");

	a_eof_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && end_of_frame |-> is_data)
		else $error("end of frame on a command byte");

	a_cmd_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !is_data |-> out_byte[7:4] == 4'hB || out_byte == 8'h00
			|| out_byte == 8'h10)
		else $error("bad command byte");

	// store clearing pass holds off requests straight after reset
	a_init_stall: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> in_stall)
		else $error("request taken during clearing pass");

endmodule

bind mono_page_framebuffer_engine mpfe_checker u_mpfe_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_stall     (in_stall),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.out_byte     (out_byte),
	.is_data      (is_data),
	.end_of_frame (end_of_frame)
);
